// File: src/snq_pkg.sv
// Shared types, constants and register map for the surface normal to quaternion block.
package snq_pkg;

    localparam int QUAT_FRAC_BITS = 14;
    localparam int SQRT_STEPS     = 32;
    localparam int REM_W          = 36;
    localparam int Q_W            = QUAT_FRAC_BITS + 2;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Y = 2'd1;
    localparam logic [1:0] REG_CENTER_Z = 2'd2;

    localparam logic [1:0] CASE_GENERAL = 2'd0;
    localparam logic [1:0] CASE_CENTER  = 2'd1;
    localparam logic [1:0] CASE_PLUS_Z  = 2'd2;
    localparam logic [1:0] CASE_MINUS_Z = 2'd3;

    localparam logic signed [31:0] CENTER_Z_RESET = -32'sd32768;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic [1:0]         case_taken;
    } quat_t;

    typedef struct packed {
        logic [63:0]      rad;
        logic [REM_W-1:0] rem;
        logic [31:0]      root;
    } sqrt_st_t;

    typedef struct packed {
        logic [31:0]                n;
        logic [2:0][32:0]           r;
        logic [2:0][Q_W-1:0]        q;
    } div_st_t;

    typedef struct packed {
        logic [29:0] ax;
        logic [29:0] ay;
        logic [29:0] az;
        logic [31:0] wr;
        logic        neg_x;
        logic        neg_y;
        logic        neg_z;
        logic [1:0]  kase;
    } side_t;

endpackage

// File: src/snq_sqrt_cell.sv
// One digit step of the pipelined integer square root.
module snq_sqrt_cell
    import snq_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  sqrt_st_t d,
    output sqrt_st_t q
);

    sqrt_st_t         st_reg;
    sqrt_st_t         st_next;
    logic [REM_W-1:0] rem_w;
    logic [REM_W-1:0] trial;

    always_comb
    begin
        rem_w = {d.rem[REM_W-3:0], d.rad[63:62]};
        trial = {{(REM_W-34){1'b0}}, d.root, 2'b01};
        st_next.rad = {d.rad[61:0], 2'b00};
        if (rem_w >= trial)
        begin
            st_next.rem  = rem_w - trial;
            st_next.root = {d.root[30:0], 1'b1};
        end
        else
        begin
            st_next.rem  = rem_w;
            st_next.root = {d.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;

endmodule

// File: src/snq_div_cell.sv
// One restoring division step for the three quaternion lanes.
module snq_div_cell
    import snq_pkg::*;
(
    input  logic    clk,
    input  logic    en,
    input  div_st_t d,
    output div_st_t q
);

    div_st_t     st_reg;
    div_st_t     st_next;
    logic [32:0] rr;
    logic        ge;

    always_comb
    begin
        rr = '0;
        ge = 1'b0;
        st_next.n = d.n;
        for (int i = 0; i < 3; i++)
        begin
            ge = d.r[i] >= {1'b0, d.n};
            rr = ge ? d.r[i] - {1'b0, d.n} : d.r[i];
            st_next.r[i] = {rr[31:0], 1'b0};
            st_next.q[i] = {d.q[i][Q_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= st_next;
        end
    end

    assign q = st_reg;

endmodule

// File: src/surface_normal_to_quaternion.sv
// Top level: point to shortest-arc quaternion pipeline with its register port.
// The block takes one point per cycle while the output is not stalled and passes it through a register
// each for the offset, the scaling, the squares and their sum, 32 cells for the first square
// root, a register for the half-angle term, squares and a sum again, 32 cells for the second
// square root, 16 division cells and the output register. When the output is stalled the
// whole chain holds, and the input is stalled with it. Registers lie at byte addresses 0, 4
// and 8 and should be written only while no item is in flight.
module surface_normal_to_quaternion
    import snq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        point_valid,
    output logic        point_stall,
    input  point_t      point,
    output logic        quat_valid,
    input  logic        quat_stall,
    output quat_t       quat,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic signed [31:0] cx_reg, cy_reg, cz_reg;
    logic               en;

    logic signed [32:0] v_reg [3];
    logic               val0_reg;
    side_t              side1_reg, side1_next;
    logic               val1_reg;
    logic [59:0]        sq_reg [3];
    side_t              side2_reg;
    logic               val2_reg;
    logic [63:0]        sum_reg;
    side_t              side3_reg;
    logic               val3_reg;

    sqrt_st_t           sq1 [SQRT_STEPS+1];
    side_t              sd1_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vd1_reg;

    side_t              side4_reg, side4_next;
    logic               val4_reg;
    logic [63:0]        sqb_reg [3];
    side_t              side5_reg;
    logic               val5_reg;
    logic [63:0]        sum2_reg;
    side_t              side6_reg;
    logic               val6_reg;

    sqrt_st_t           sq2 [SQRT_STEPS+1];
    side_t              sd2_reg [SQRT_STEPS];
    logic [SQRT_STEPS-1:0] vd2_reg;

    div_st_t            dv [Q_W+1];
    side_t              sd3_reg [Q_W];
    logic [Q_W-1:0]     vd3_reg;

    quat_t              out_reg, out_next;
    logic               out_valid_reg;

    logic [32:0]        mag [3];
    logic [32:0]        mx;
    logic [Q_W:0]       rnd [3];
    logic signed [31:0] fr [3];
    logic signed [15:0] one16;

    assign en          = !(out_valid_reg && quat_stall);
    assign point_stall = !en;
    assign quat_valid  = out_valid_reg;
    assign quat        = out_reg;
    assign pready      = 1'b1;
    assign one16       = 16'(32'sd1 <<< QUAT_FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= CENTER_Z_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_CENTER_X: cx_reg <= pwdata;
                REG_CENTER_Y: cy_reg <= pwdata;
                REG_CENTER_Z: cz_reg <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CENTER_X: prdata = cx_reg;
            REG_CENTER_Y: prdata = cy_reg;
            REG_CENTER_Z: prdata = cz_reg;
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v_reg[i][32] ? 33'(-v_reg[i]) : 33'(v_reg[i]);
        end
        mx = mag[0];
        if (mag[1] > mx)
        begin
            mx = mag[1];
        end
        if (mag[2] > mx)
        begin
            mx = mag[2];
        end
        if (mx[32:30] == 3'd0)
        begin
            side1_next.ax = mag[0][29:0];
            side1_next.ay = mag[1][29:0];
            side1_next.az = mag[2][29:0];
        end
        else if (mx[32:31] == 2'd0)
        begin
            side1_next.ax = mag[0][30:1];
            side1_next.ay = mag[1][30:1];
            side1_next.az = mag[2][30:1];
        end
        else if (!mx[32])
        begin
            side1_next.ax = mag[0][31:2];
            side1_next.ay = mag[1][31:2];
            side1_next.az = mag[2][31:2];
        end
        else
        begin
            side1_next.ax = mag[0][32:3];
            side1_next.ay = mag[1][32:3];
            side1_next.az = mag[2][32:3];
        end
        side1_next.wr    = '0;
        side1_next.neg_x = !v_reg[1][32] && (v_reg[1] != '0);
        side1_next.neg_y = v_reg[0][32];
        side1_next.neg_z = v_reg[2][32];
        if (side1_next.ax == '0 && side1_next.ay == '0 && side1_next.az == '0)
        begin
            side1_next.kase = CASE_CENTER;
        end
        else if (side1_next.ax == '0 && side1_next.ay == '0 && !v_reg[2][32]
                 && (v_reg[2] != '0))
        begin
            side1_next.kase = CASE_PLUS_Z;
        end
        else if (side1_next.ax == '0 && side1_next.ay == '0)
        begin
            side1_next.kase = CASE_MINUS_Z;
        end
        else
        begin
            side1_next.kase = CASE_GENERAL;
        end
    end

    always_comb
    begin
        side4_next = sd1_reg[SQRT_STEPS-1];
        if (side4_next.neg_z)
        begin
            side4_next.wr = sq1[SQRT_STEPS].root - 32'(side4_next.az);
        end
        else
        begin
            side4_next.wr = sq1[SQRT_STEPS].root + 32'(side4_next.az);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg[0] <= 33'(point.point_x) - 33'(cx_reg);
            v_reg[1] <= 33'(point.point_y) - 33'(cy_reg);
            v_reg[2] <= 33'(point.point_z) - 33'(cz_reg);
            side1_reg <= side1_next;
            sq_reg[0] <= 60'(side1_reg.ax) * 60'(side1_reg.ax);
            sq_reg[1] <= 60'(side1_reg.ay) * 60'(side1_reg.ay);
            sq_reg[2] <= 60'(side1_reg.az) * 60'(side1_reg.az);
            side2_reg <= side1_reg;
            sum_reg <= 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
            side3_reg <= side2_reg;
            sd1_reg[0] <= side3_reg;
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                sd1_reg[i] <= sd1_reg[i-1];
            end
            side4_reg <= side4_next;
            sqb_reg[0] <= 64'(side4_reg.ax) * 64'(side4_reg.ax);
            sqb_reg[1] <= 64'(side4_reg.ay) * 64'(side4_reg.ay);
            sqb_reg[2] <= 64'(side4_reg.wr) * 64'(side4_reg.wr);
            side5_reg <= side4_reg;
            sum2_reg <= sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
            side6_reg <= side5_reg;
            sd2_reg[0] <= side6_reg;
            for (int i = 1; i < SQRT_STEPS; i++)
            begin
                sd2_reg[i] <= sd2_reg[i-1];
            end
            sd3_reg[0] <= sd2_reg[SQRT_STEPS-1];
            for (int i = 1; i < Q_W; i++)
            begin
                sd3_reg[i] <= sd3_reg[i-1];
            end
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val0_reg      <= 1'b0;
            val1_reg      <= 1'b0;
            val2_reg      <= 1'b0;
            val3_reg      <= 1'b0;
            vd1_reg       <= '0;
            val4_reg      <= 1'b0;
            val5_reg      <= 1'b0;
            val6_reg      <= 1'b0;
            vd2_reg       <= '0;
            vd3_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            val0_reg      <= point_valid;
            val1_reg      <= val0_reg;
            val2_reg      <= val1_reg;
            val3_reg      <= val2_reg;
            vd1_reg       <= {vd1_reg[SQRT_STEPS-2:0], val3_reg};
            val4_reg      <= vd1_reg[SQRT_STEPS-1];
            val5_reg      <= val4_reg;
            val6_reg      <= val5_reg;
            vd2_reg       <= {vd2_reg[SQRT_STEPS-2:0], val6_reg};
            vd3_reg       <= {vd3_reg[Q_W-2:0], vd2_reg[SQRT_STEPS-1]};
            out_valid_reg <= vd3_reg[Q_W-1];
        end
    end

    assign sq1[0] = '{rad: sum_reg, rem: '0, root: '0};
    assign sq2[0] = '{rad: sum2_reg, rem: '0, root: '0};

    generate
        for (genvar g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            snq_sqrt_cell u_len_cell
            (
                .clk (clk),
                .en  (en),
                .d   (sq1[g]),
                .q   (sq1[g+1])
            );
            snq_sqrt_cell u_norm_cell
            (
                .clk (clk),
                .en  (en),
                .d   (sq2[g]),
                .q   (sq2[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        dv[0].n    = sq2[SQRT_STEPS].root;
        dv[0].r[0] = 33'(sd2_reg[SQRT_STEPS-1].ay);
        dv[0].r[1] = 33'(sd2_reg[SQRT_STEPS-1].ax);
        dv[0].r[2] = 33'(sd2_reg[SQRT_STEPS-1].wr);
        dv[0].q    = '0;
    end

    generate
        for (genvar g = 0; g < Q_W; g++)
        begin : g_div
            snq_div_cell u_div_cell
            (
                .clk (clk),
                .en  (en),
                .d   (dv[g]),
                .q   (dv[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = {1'b0, dv[Q_W].q[i]} + (Q_W+1)'(1);
            fr[i]  = 32'(rnd[i][Q_W:1]);
        end
        out_next.quat_z     = '0;
        out_next.case_taken = sd3_reg[Q_W-1].kase;
        case (sd3_reg[Q_W-1].kase)
            CASE_CENTER, CASE_PLUS_Z:
            begin
                out_next.quat_x = '0;
                out_next.quat_y = '0;
                out_next.quat_w = one16;
            end
            CASE_MINUS_Z:
            begin
                out_next.quat_x = one16;
                out_next.quat_y = '0;
                out_next.quat_w = '0;
            end
            default:
            begin
                out_next.quat_x = sd3_reg[Q_W-1].neg_x ? 16'(-fr[0]) : 16'(fr[0]);
                out_next.quat_y = sd3_reg[Q_W-1].neg_y ? 16'(-fr[1]) : 16'(fr[1]);
                out_next.quat_w = 16'(fr[2]);
            end
        endcase
    end

endmodule
